// ----- rtl/kare_pkg.sv -----
// Shared types and constants for the key auto-repeat event block.
package kare_pkg;

  localparam int unsigned CFG_W    = 12;
  localparam int unsigned ACC_W    = 16;
  localparam int unsigned THR_W    = CFG_W + 1;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned NSLOTS   = 3;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned BURST_W  = 7;

  localparam logic [BURST_W-1:0] MAX_BURST = 7'd64;
  localparam logic [ACC_W-1:0]   ACC_MAX   = 16'hFFFF;

  // key codes
  localparam logic [FUNC_W-1:0] FUNC_LEFT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROT_CCW  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROT_CW   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SOFTDROP = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_HARDDROP = 3'd5;

  // register indexes
  localparam logic [1:0] REG_MOVE_DELAY = 2'd0;
  localparam logic [1:0] REG_MOVE_RATE  = 2'd1;
  localparam logic [1:0] REG_DROP_DELAY = 2'd2;
  localparam logic [1:0] REG_DROP_RATE  = 2'd3;

  localparam logic [CFG_W-1:0] MOVE_DELAY_RST = 12'd150;
  localparam logic [CFG_W-1:0] MOVE_RATE_RST  = 12'd30;
  localparam logic [CFG_W-1:0] DROP_DELAY_RST = 12'd50;
  localparam logic [CFG_W-1:0] DROP_RATE_RST  = 12'd50;

  typedef enum logic {
    KIND_HOLD,
    KIND_BUTTON
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [FUNC_W-1:0] act;
    logic              pressed;
    logic [CFG_W-1:0]  elapsed;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] move_delay;
    logic [CFG_W-1:0] move_rate;
    logic [CFG_W-1:0] drop_delay;
    logic [CFG_W-1:0] drop_rate;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

endpackage

// ----- rtl/kare_front.sv -----
// Front end: accepts key reports, decodes them into commands for the queue.
module kare_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kare_pkg::FUNC_W-1:0]  func,
  input  logic                         pressed,
  input  logic [kare_pkg::CFG_W-1:0]   elapsed_ms,
  input  logic                         q_full,
  output logic                         q_push,
  output kare_pkg::cmd_t               q_cmd
);
  import kare_pkg::*;

  logic known;

  always_comb begin
    known        = 1'b1;
    q_cmd.kind   = KIND_HOLD;
    q_cmd.slot   = 2'd0;
    q_cmd.act    = func;
    q_cmd.pressed = pressed;
    q_cmd.elapsed = elapsed_ms;
    case (func)
      FUNC_LEFT: begin
        q_cmd.slot = 2'd0;
      end
      FUNC_RIGHT: begin
        q_cmd.slot = 2'd1;
      end
      FUNC_SOFTDROP: begin
        q_cmd.slot = 2'd2;
      end
      FUNC_ROT_CCW: begin
        q_cmd.kind = KIND_BUTTON;
        q_cmd.slot = 2'd0;
      end
      FUNC_ROT_CW: begin
        q_cmd.kind = KIND_BUTTON;
        q_cmd.slot = 2'd1;
      end
      FUNC_HARDDROP: begin
        q_cmd.kind = KIND_BUTTON;
        q_cmd.slot = 2'd2;
      end
      default: begin
        known = 1'b0;  // unused codes are taken and dropped
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && known;

endmodule

// ----- rtl/kare_queue.sv -----
// Two-entry command queue between the front end and the repeat engine.
module kare_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kare_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output kare_pkg::cmd_t pop_cmd
);
  import kare_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop && pop_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = mem[rd_ptr];

endmodule

// ----- rtl/kare_back.sv -----
// Repeat engine: key state, burst generation and the output register.
module kare_back (
  input  logic                         clk,
  input  logic                         rst,
  input  kare_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  kare_pkg::cmd_t               q_cmd,
  output kare_pkg::bk_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kare_pkg::FUNC_W-1:0]  action,
  output logic                         last
);
  import kare_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [ACC_W-1:0]     hold_time [NSLOTS];
  logic [NSLOTS-1:0]    button_latched;
  logic [ACC_W-1:0]     acc;
  logic [CFG_W-1:0]     rate;
  logic [THR_W-1:0]     thr;
  logic [BURST_W-1:0]   n;
  logic                 first;

  logic                 out_free;
  logic [ACC_W:0]       sum;
  logic [CFG_W-1:0]     sel_delay;
  logic [CFG_W-1:0]     sel_rate;
  logic [ACC_W-1:0]     acc_sub;
  logic                 rep_ok;
  logic                 rep_more;
  logic                 first_more;
  logic                 emit_go;

  always_comb begin
    out_free   = !out_valid || out_ready;
    sum        = {1'b0, hold_time[cmd.slot]} + {{(ACC_W + 1 - CFG_W){1'b0}}, cmd.elapsed};
    sel_delay  = (cmd.slot == 2'd2) ? cfg.drop_delay : cfg.move_delay;
    sel_rate   = (cmd.slot == 2'd2) ? cfg.drop_rate : cfg.move_rate;
    if (sel_rate == '0) begin
      sel_rate = 12'd1;
    end
    acc_sub    = acc - {{(ACC_W - CFG_W){1'b0}}, rate};
    // rate >= 1, so reaching delay+rate implies reaching delay
    rep_ok     = (acc >= {{(ACC_W - THR_W){1'b0}}, thr}) && (n < MAX_BURST);
    rep_more   = (acc_sub >= {{(ACC_W - THR_W){1'b0}}, thr}) &&
                 ((n + 7'd1) < MAX_BURST);
    first_more = (acc >= {{(ACC_W - THR_W){1'b0}}, thr}) && (7'd1 < MAX_BURST);
    // a result is loaded into the output register this cycle
    emit_go    = out_free &&
                 (((state == ST_EXEC) && (cmd.kind == KIND_BUTTON) &&
                   !button_latched[cmd.slot] && cmd.pressed) ||
                  ((state == ST_RUN) && (first || rep_ok)));
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.pop  = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      button_latched <= '0;
      for (int i = 0; i < NSLOTS; i++) begin
        hold_time[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd.kind == KIND_BUTTON) begin
            if (!button_latched[cmd.slot] && cmd.pressed) begin
              if (out_free) begin
                action                   <= cmd.act;
                last                     <= 1'b1;
                button_latched[cmd.slot] <= 1'b1;
                state                    <= ST_IDLE;
              end
            end else begin
              if (!cmd.pressed) begin
                button_latched[cmd.slot] <= 1'b0;
              end
              state <= ST_IDLE;
            end
          end else if (!cmd.pressed) begin
            hold_time[cmd.slot] <= '0;
            state               <= ST_IDLE;
          end else begin
            first <= (hold_time[cmd.slot] == '0);
            acc   <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            rate  <= sel_rate;
            thr   <= {1'b0, sel_delay} + {1'b0, sel_rate};
            n     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (first) begin
            if (out_free) begin
              action    <= cmd.act;
              last      <= !first_more;
              first     <= 1'b0;
              n         <= 7'd1;
              if (!first_more) begin
                hold_time[cmd.slot] <= acc;
                state               <= ST_IDLE;
              end
            end
          end else if (rep_ok) begin
            if (out_free) begin
              action    <= cmd.act;
              last      <= !rep_more;
              acc       <= acc_sub;
              n         <= n + 7'd1;
              if (!rep_more) begin
                hold_time[cmd.slot] <= acc_sub;
                state               <= ST_IDLE;
              end
            end
          end else begin
            // held key with nothing to emit this report
            hold_time[cmd.slot] <= acc;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/key_auto_repeat_events_core.sv -----
// Key auto-repeat event generator: top level with register file and assertions.
// A popped item is decoded in EXEC; rotate and hard drop emit from EXEC, held keys from RUN.
// The engine takes one item at a time: a held repeating key emits up to 64 results per report,
//   and a stalled result holds the engine until the output register is free.
// A two-entry command queue lets new items enter while a burst drains.
// Synchronous reset restores registers to 150/30/50/50 and clears all key state.
module key_auto_repeat_events_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kare_pkg::ADDR_W-1:0]  paddr,
  input  logic [kare_pkg::DATA_W-1:0]  pwdata,
  output logic [kare_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kare_pkg::FUNC_W-1:0]  func,
  input  logic                         pressed,
  input  logic [kare_pkg::CFG_W-1:0]   elapsed_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kare_pkg::FUNC_W-1:0]  action,
  output logic                         last
);
  import kare_pkg::*;

  cfg_t     cfg;
  logic     q_full;
  logic     q_push;
  cmd_t     q_in;
  logic     q_valid;
  cmd_t     q_out;
  bk_stat_t stat;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_delay <= MOVE_DELAY_RST;
      cfg.move_rate  <= MOVE_RATE_RST;
      cfg.drop_delay <= DROP_DELAY_RST;
      cfg.drop_rate  <= DROP_RATE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MOVE_DELAY: cfg.move_delay <= pwdata[CFG_W-1:0];
        REG_MOVE_RATE:  cfg.move_rate  <= pwdata[CFG_W-1:0];
        REG_DROP_DELAY: cfg.drop_delay <= pwdata[CFG_W-1:0];
        REG_DROP_RATE:  cfg.drop_rate  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MOVE_DELAY: prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.move_delay};
      REG_MOVE_RATE:  prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.move_rate};
      REG_DROP_DELAY: prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.drop_delay};
      REG_DROP_RATE:  prdata = {{(DATA_W - CFG_W){1'b0}}, cfg.drop_rate};
      default:        prdata = '0;
    endcase
  end

  kare_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .pressed    (pressed),
    .elapsed_ms (elapsed_ms),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  kare_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (stat.pop),
    .pop_cmd   (q_out)
  );

  kare_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_out),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .last      (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command pushed into a full queue");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> (!stat.busy && q_valid))
    else $error("queue popped while engine busy");

  a_pop_starts_work: assert property (@(posedge clk) disable iff (rst)
    stat.pop |=> stat.busy)
    else $error("engine did not start on popped command");

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (action <= FUNC_HARDDROP))
    else $error("result carries an unused key code");

endmodule
